[hdl/dmbq_pkg.sv]
// ----------------------------------------------------------------------------
// dmbq_pkg
// Shared widths, configuration layout, history word and MAC operation type
// for the dual-mode biquad band-pass mixer.
// ----------------------------------------------------------------------------
package dmbq_pkg;

  // Channel count and history memory addressing
  localparam int CHANNELS = 16;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int CH_W      = 4;
  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 16;
  localparam int COEF_W    = 24;
  localparam int FB_W      = 48;
  localparam int ENABLE_W  = 16;
  localparam int IN_DATA_W = 32;

  // Arithmetic widths: one extra bit lets unsigned gains share the signed multiplier
  localparam int OP_W   = 25;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = 56;

  // Configuration port
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_ONE_B0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_ONE_FB   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_TWO_B0   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_TWO_FB   = 3'd7;

  localparam logic [GAIN_W-1:0] WET_GAIN_RESET = 16'd32768;

  // Saturation limits and rounding offsets at accumulator width
  localparam logic signed [ACC_W-1:0] SAT_HI = 56'sd8388607;
  localparam logic signed [ACC_W-1:0] SAT_LO = -56'sd8388608;
  localparam logic signed [ACC_W-1:0] RND_STAGE = 56'sd2097152;
  localparam logic signed [ACC_W-1:0] RND_MIX   = 56'sd16384;
  localparam int SHIFT_STAGE = 22;
  localparam int SHIFT_MIX   = 15;

  typedef struct packed {
    logic                       filter_mode;
    logic [ENABLE_W-1:0]        channel_enable;
    logic [GAIN_W-1:0]          wet_gain;
    logic [GAIN_W-1:0]          dry_gain;
    logic signed [COEF_W-1:0]   stage_one_b0;
    logic [FB_W-1:0]            stage_one_feedback;
    logic signed [COEF_W-1:0]   stage_two_b0;
    logic [FB_W-1:0]            stage_two_feedback;
  } cfg_t;

  // One channel's history: first-stage inputs, first-stage outputs, low-pass outputs
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] z2;
    logic signed [SAMPLE_W-1:0] z1;
    logic signed [SAMPLE_W-1:0] y2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] x1;
  } hist_t;

  localparam int HIST_W = $bits(hist_t);

  // One multiply issued to the MAC, with how its product is accumulated
  typedef struct packed {
    logic                   issue;
    logic                   first;
    logic                   neg;
    logic                   dbl;
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
  } mac_op_t;

  function automatic logic signed [OP_W-1:0] sext_op(input logic [SAMPLE_W-1:0] v);
    return {{(OP_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  function automatic logic signed [OP_W-1:0] zext_op(input logic [GAIN_W-1:0] v);
    return {{(OP_W - GAIN_W){1'b0}}, v};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/dual_mode_biquad_bandpass_mixer_core.sv]
// ----------------------------------------------------------------------------
// dual_mode_biquad_bandpass_mixer_core
// Per-channel biquad band-pass mixer: one Q1.23 sample in, one sample out.
//
// Input stream s_*: one word per sample with its flat channel index.
// Output stream m_*: one word per input, in order. Configuration is a plain
// write port (cfg_we, cfg_index, cfg_data), to be written only while idle; the block does not enforce this.
// Per-channel history (x1, x2, y1, y2 of stage one, z1, z2 of stage two)
// lives in one 144-bit-wide RAM with one entry per channel. It is read when a
// word is accepted and written back when its filtered result is loaded.
// One item is processed at a time on a single shared 25x25 MAC, so the MAC
// schedule sets the rate: a channel that passes through skips the MAC, band-pass
// mode runs steps BP_X0 to BP_LAST and cascade mode steps CS_X0 to CS_LAST;
// the next word is taken only once the current result is loaded.
// The output register lets a new word be taken while a result waits. If the
// receiver stalls with a result waiting, the next item holds at its last step.
// Reset sets configuration to its defaults (wet gain 32768, all else zero) and
// marks every channel's history as zero through per-channel valid bits; an
// enable bit rising does the same for that channel. No clearing pass is needed.
// ----------------------------------------------------------------------------
module dual_mode_biquad_bandpass_mixer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dmbq_pkg::IN_DATA_W-1:0] s_tdata,   // [3:0] channel, [27:4] sample_in
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dmbq_pkg::SAMPLE_W-1:0]  m_tdata,   // [23:0] sample_out
  input  logic                           cfg_we,
  input  logic [dmbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmbq_pkg::CFG_W-1:0]     cfg_data
);
  import dmbq_pkg::*;

  // Band-pass schedule steps
  localparam logic [3:0] BP_X0   = 4'd0;
  localparam logic [3:0] BP_X2   = 4'd1;
  localparam logic [3:0] BP_Y1   = 4'd2;
  localparam logic [3:0] BP_Y2   = 4'd3;
  localparam logic [3:0] BP_DRY  = 4'd4;
  localparam logic [3:0] BP_WET  = 4'd5;
  localparam logic [3:0] BP_MIXW = 4'd6;
  localparam logic [3:0] BP_LAST = 4'd8;
  // Cascade schedule steps
  localparam logic [3:0] CS_X0   = 4'd0;
  localparam logic [3:0] CS_X1   = 4'd1;
  localparam logic [3:0] CS_X2   = 4'd2;
  localparam logic [3:0] CS_Y1   = 4'd3;
  localparam logic [3:0] CS_Y2   = 4'd4;
  localparam logic [3:0] CS_U1   = 4'd5;
  localparam logic [3:0] CS_U2   = 4'd6;
  localparam logic [3:0] CS_Z1   = 4'd7;
  localparam logic [3:0] CS_Z2   = 4'd8;
  localparam logic [3:0] CS_HP   = 4'd9;
  localparam logic [3:0] CS_DRY  = 4'd10;
  localparam logic [3:0] CS_WET  = 4'd11;
  localparam logic [3:0] CS_MIXW = 4'd12;
  localparam logic [3:0] CS_LAST = 4'd14;
  localparam logic [3:0] PT_LAST = 4'd0;

  cfg_t                       cfg;
  logic [CHANNELS-1:0]        clear_mask;
  logic [CHANNELS-1:0]        hist_valid;
  logic [CHANNELS-1:0]        hist_valid_next;
  mac_op_t                    op;
  logic signed [SAMPLE_W-1:0] stage_res;
  logic signed [SAMPLE_W-1:0] mix_res;

  logic                       accept;
  logic [CH_W-1:0]            in_ch;
  logic [SAMPLE_W-1:0]        in_x;
  logic                       in_range;
  logic [CH_AW-1:0]           in_addr;

  logic                       busy;
  logic [3:0]                 step;
  logic [3:0]                 last_step;
  logic [CH_AW-1:0]           ch_addr;
  logic signed [SAMPLE_W-1:0] x_reg;
  logic                       bypass;
  logic                       hist_ok;
  logic signed [SAMPLE_W-1:0] hp;
  logic signed [SAMPLE_W-1:0] wet;
  logic                       out_valid;
  logic [SAMPLE_W-1:0]        out_data;

  logic [HIST_W-1:0]          rdata;
  hist_t                      hist;
  hist_t                      hist_new;
  logic                       finish;
  logic                       load;
  logic                       wb;

  logic signed [COEF_W-1:0]   a11;
  logic signed [COEF_W-1:0]   a12;
  logic signed [COEF_W-1:0]   a21;
  logic signed [COEF_W-1:0]   a22;

  dmbq_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .clear_mask (clear_mask)
  );

  // Unpack the input word
  assign in_ch    = s_tdata[CH_W-1:0];
  assign in_x     = s_tdata[CH_W +: SAMPLE_W];
  assign in_range = 32'(in_ch) < CHANNELS;
  assign in_addr  = CH_AW'(in_ch);
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  // History memory: read on accept, write back when a filtered result is loaded
  dmbq_ram #(
    .WIDTH (HIST_W),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (wb),
    .waddr (ch_addr),
    .wdata (hist_new),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rdata)
  );

  // History never written since reset or enable reads as zero
  assign hist = hist_ok ? hist_t'(rdata) : '0;

  assign a11 = cfg.stage_one_feedback[FB_W-1:COEF_W];
  assign a12 = cfg.stage_one_feedback[COEF_W-1:0];
  assign a21 = cfg.stage_two_feedback[FB_W-1:COEF_W];
  assign a22 = cfg.stage_two_feedback[COEF_W-1:0];

  // Step at which the item completes
  always_comb begin
    if (bypass) begin
      last_step = PT_LAST;
    end else if (cfg.filter_mode) begin
      last_step = CS_LAST;
    end else begin
      last_step = BP_LAST;
    end
  end

  assign finish = busy && (step == last_step);
  assign load   = finish && (!out_valid || m_tready);
  assign wb     = load && !bypass;

  // MAC schedule
  always_comb begin
    op = '0;
    if (busy && !bypass) begin
      if (!cfg.filter_mode) begin
        case (step)
          BP_X0: begin
            op.issue = 1'b1; op.first = 1'b1;
            op.a = sext_op(cfg.stage_one_b0); op.b = sext_op(x_reg);
          end
          BP_X2: begin
            op.issue = 1'b1; op.neg = 1'b1;
            op.a = sext_op(cfg.stage_one_b0); op.b = sext_op(hist.x2);
          end
          BP_Y1: begin
            op.issue = 1'b1; op.neg = 1'b1;
            op.a = sext_op(a11); op.b = sext_op(hist.y1);
          end
          BP_Y2: begin
            op.issue = 1'b1; op.neg = 1'b1;
            op.a = sext_op(a12); op.b = sext_op(hist.y2);
          end
          BP_DRY: begin
            op.issue = 1'b1; op.first = 1'b1;
            op.a = sext_op(x_reg); op.b = zext_op(cfg.dry_gain);
          end
          BP_MIXW: begin
            op.issue = 1'b1;
            op.a = sext_op(wet); op.b = zext_op(cfg.wet_gain);
          end
          default: ;
        endcase
      end else begin
        case (step)
          CS_X0: begin
            op.issue = 1'b1; op.first = 1'b1;
            op.a = sext_op(cfg.stage_one_b0); op.b = sext_op(x_reg);
          end
          CS_X1: begin
            op.issue = 1'b1; op.neg = 1'b1; op.dbl = 1'b1;
            op.a = sext_op(cfg.stage_one_b0); op.b = sext_op(hist.x1);
          end
          CS_X2: begin
            op.issue = 1'b1;
            op.a = sext_op(cfg.stage_one_b0); op.b = sext_op(hist.x2);
          end
          CS_Y1: begin
            op.issue = 1'b1; op.neg = 1'b1;
            op.a = sext_op(a11); op.b = sext_op(hist.y1);
          end
          CS_Y2: begin
            op.issue = 1'b1; op.neg = 1'b1;
            op.a = sext_op(a12); op.b = sext_op(hist.y2);
          end
          CS_U1: begin
            op.issue = 1'b1; op.first = 1'b1; op.dbl = 1'b1;
            op.a = sext_op(cfg.stage_two_b0); op.b = sext_op(hist.y1);
          end
          CS_U2: begin
            op.issue = 1'b1;
            op.a = sext_op(cfg.stage_two_b0); op.b = sext_op(hist.y2);
          end
          CS_Z1: begin
            op.issue = 1'b1; op.neg = 1'b1;
            op.a = sext_op(a21); op.b = sext_op(hist.z1);
          end
          CS_Z2: begin
            op.issue = 1'b1; op.neg = 1'b1;
            op.a = sext_op(a22); op.b = sext_op(hist.z2);
          end
          CS_HP: begin
            op.issue = 1'b1;
            op.a = sext_op(cfg.stage_two_b0); op.b = sext_op(hp);
          end
          CS_DRY: begin
            op.issue = 1'b1; op.first = 1'b1;
            op.a = sext_op(x_reg); op.b = zext_op(cfg.dry_gain);
          end
          CS_MIXW: begin
            op.issue = 1'b1;
            op.a = sext_op(wet); op.b = zext_op(cfg.wet_gain);
          end
          default: ;
        endcase
      end
    end
  end

  dmbq_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .stage_res (stage_res),
    .mix_res   (mix_res)
  );

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      step <= '0;
    end else if (load) begin
      busy <= 1'b0;
    end else if (busy && !finish) begin
      step <= step + 4'd1;
    end
  end

  // Item payload captured at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_addr <= in_addr;
      x_reg   <= in_x;
      bypass  <= !(in_range && cfg.channel_enable[in_ch]);
      hist_ok <= in_range && hist_valid[in_addr];
    end
  end

  // Latch stage outputs once their sums are complete
  always_ff @(posedge clk) begin
    if (busy && !bypass) begin
      if (cfg.filter_mode) begin
        if (step == CS_U2) begin
          hp <= stage_res;
        end
        if (step == CS_WET) begin
          wet <= stage_res;
        end
      end else if (step == BP_WET) begin
        wet <= stage_res;
      end
    end
  end

  // Shift the delay lines for write-back
  always_comb begin
    hist_new.x1 = x_reg;
    hist_new.x2 = hist.x1;
    hist_new.y2 = hist.y1;
    if (cfg.filter_mode) begin
      hist_new.y1 = hp;
      hist_new.z1 = wet;
      hist_new.z2 = hist.z1;
    end else begin
      hist_new.y1 = wet;
      hist_new.z1 = hist.z1;
      hist_new.z2 = hist.z2;
    end
  end

  // Per-channel history valid bits
  always_comb begin
    hist_valid_next = hist_valid & ~clear_mask;
    if (wb) begin
      hist_valid_next[ch_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else begin
      hist_valid <= hist_valid_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= bypass ? x_reg : mix_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

[hdl/dmbq_ram.sv]
// ----------------------------------------------------------------------------
// dmbq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dmbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/dmbq_cfg.sv]
// ----------------------------------------------------------------------------
// dmbq_cfg
// Configuration register file. Flags channels whose enable bit rises so that
// their history is treated as cleared.
// ----------------------------------------------------------------------------
module dmbq_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dmbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmbq_pkg::CFG_W-1:0]     cfg_data,
  output dmbq_pkg::cfg_t                 cfg,
  output logic [dmbq_pkg::CHANNELS-1:0]  clear_mask
);
  import dmbq_pkg::*;

  logic [31:0] en_old;
  logic [31:0] en_new;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode        <= 1'b0;
      cfg.channel_enable     <= '0;
      cfg.wet_gain           <= WET_GAIN_RESET;
      cfg.dry_gain           <= '0;
      cfg.stage_one_b0       <= '0;
      cfg.stage_one_feedback <= '0;
      cfg.stage_two_b0       <= '0;
      cfg.stage_two_feedback <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_MODE:    cfg.filter_mode        <= cfg_data[0];
        REG_CHANNEL_ENABLE: cfg.channel_enable     <= cfg_data[ENABLE_W-1:0];
        REG_WET_GAIN:       cfg.wet_gain           <= cfg_data[GAIN_W-1:0];
        REG_DRY_GAIN:       cfg.dry_gain           <= cfg_data[GAIN_W-1:0];
        REG_STAGE_ONE_B0:   cfg.stage_one_b0       <= cfg_data[COEF_W-1:0];
        REG_STAGE_ONE_FB:   cfg.stage_one_feedback <= cfg_data[FB_W-1:0];
        REG_STAGE_TWO_B0:   cfg.stage_two_b0       <= cfg_data[COEF_W-1:0];
        REG_STAGE_TWO_FB:   cfg.stage_two_feedback <= cfg_data[FB_W-1:0];
        default: ;
      endcase
    end
  end

  // Flag a 0 to 1 change of each channel's enable bit
  assign en_old = 32'(cfg.channel_enable);
  assign en_new = 32'(cfg_data[ENABLE_W-1:0]);

  always_comb begin
    clear_mask = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < ENABLE_W) begin
        clear_mask[c] = cfg_we && (cfg_index == REG_CHANNEL_ENABLE) && en_new[c] && !en_old[c];
      end
    end
  end

endmodule

[hdl/dmbq_mac.sv]
// ----------------------------------------------------------------------------
// dmbq_mac
// Shared multiply-accumulate: registered 25x25 product, then a scaled add into
// a 56-bit accumulator, with rounded and saturated stage and mix views.
// ----------------------------------------------------------------------------
module dmbq_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  dmbq_pkg::mac_op_t                   op,
  output logic signed [dmbq_pkg::SAMPLE_W-1:0] stage_res,
  output logic signed [dmbq_pkg::SAMPLE_W-1:0] mix_res
);
  import dmbq_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  logic                     p_first;
  logic                     p_neg;
  logic                     p_dbl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  stage_sh;
  logic signed [ACC_W-1:0]  mix_sh;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= op.issue;
    end
    prod    <= op.a * op.b;
    p_first <= op.first;
    p_neg   <= op.neg;
    p_dbl   <= op.dbl;
  end

  // Scale the product and add it in
  always_comb begin
    term = ACC_W'(prod);
    if (p_dbl) begin
      term = term <<< 1;
    end
    if (p_neg) begin
      term = -term;
    end
    acc_next = (p_first ? '0 : acc) + term;
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= acc_next;
    end
  end

  // Round half up and saturate
  assign stage_sh  = (acc + RND_STAGE) >>> SHIFT_STAGE;
  assign mix_sh    = (acc + RND_MIX) >>> SHIFT_MIX;
  assign stage_res = sat24(stage_sh);
  assign mix_res   = sat24(mix_sh);

endmodule

[hdl/dmbq_checker.sv]
// ----------------------------------------------------------------------------
// dmbq_checker
// Port-level checks for the mixer core: reset, one word in flight, results only from an item, output hold.
// ----------------------------------------------------------------------------
module dmbq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dmbq_pkg::SAMPLE_W-1:0] m_tdata
);
  import dmbq_pkg::*;

  // Drop any waiting result on reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Hold one word at a time: no new word right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word taken while busy");

  // A fresh result only comes from an item that was in progress
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared with no item in progress");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind dual_mode_biquad_bandpass_mixer_core dmbq_checker u_dmbq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
